>>> hdl/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// Trial division prime test package
// Sequencer state encoding shared by the prime test unit.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_FINISH
  } tdpt_state_e;

endpackage

>>> hdl/tdpt_divider.sv
// ----------------------------------------------------------------------------
// Trial division prime test divider
// Restoring divider that produces quotient and remainder, one bit per cycle.
// The dividend and divisor inputs must stay stable while a division runs.
// ----------------------------------------------------------------------------
module tdpt_divider #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quotient_o,
  output logic [WIDTH-1:0] remainder_o
);

  localparam int unsigned CntWidth = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic [WIDTH-1:0]    quo_q, quo_d;
  logic [WIDTH-1:0]    rem_q, rem_d;
  logic [WIDTH:0]      shifted;
  logic [WIDTH:0]      diff;
  logic                ge;

  assign shifted = {rem_q, quo_q[WIDTH-1]};
  assign ge      = (shifted >= {1'b0, divisor_i});
  assign diff    = shifted - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntWidth'(WIDTH - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
      quo_d = {quo_q[WIDTH-2:0], ge};
      cnt_d = cnt_q - CntWidth'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

>>> hdl/trial_division_prime_test_unit.sv
// ----------------------------------------------------------------------------
// Trial division prime test unit
// Classifies one unsigned number per transaction as prime or not, and flags
// whether it is even or odd.
//
// The input channel (in_valid_i, in_ready_o, number_i) takes one number per
// transaction. The output channel (out_valid_o, out_ready_i, is_prime_o,
// is_even_o, is_odd_o) returns exactly one result per input transaction.
// Numbers below four and even numbers are decided at once; ST_FINISH loads their
// result once the output register is free. An odd number of five or more is divided
// by the trial divisors 3, 5, 7, ... until a divisor leaves remainder zero or
// exceeds the quotient. Each trial divisor runs one division in the bit-serial divider.
// One number is in work at a time; in_ready_o rises the cycle after the result loads.
// The result sits in an output register, so a new number is accepted while a
// result still waits; a stalled receiver holds the next result in the
// sequencer until the output register frees. Reset clears all control state
// and drops both valid and ready-related state to idle.
// ----------------------------------------------------------------------------
module trial_division_prime_test_unit #(
  parameter int unsigned NUMBER_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [NUMBER_WIDTH-1:0] number_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    is_prime_o,
  output logic                    is_even_o,
  output logic                    is_odd_o
);

  localparam int unsigned W = NUMBER_WIDTH;

  tdpt_pkg::tdpt_state_e state_q, state_d;

  logic [W-1:0] n_q;
  logic [W-1:0] d_q;
  logic         prime_q;
  logic         even_q;
  logic         out_valid_q;
  logic         out_prime_q;
  logic         out_even_q;

  logic         div_start;
  logic         div_done;
  logic [W-1:0] div_quo;
  logic [W-1:0] div_rem;
  logic         in_fire;
  logic         out_load;
  logic         small_n;
  logic         trial_over;
  logic         trial_hit;

  assign in_fire    = in_valid_i && in_ready_o;
  assign small_n    = (number_i < W'(4));
  assign trial_over = (d_q > div_quo);
  assign trial_hit  = (div_rem == '0);

  tdpt_divider #(
    .WIDTH(W)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (n_q),
    .divisor_i   (d_q),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      tdpt_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (small_n || !number_i[0]) begin
            state_d = tdpt_pkg::ST_FINISH;
          end else begin
            state_d = tdpt_pkg::ST_START;
          end
        end
      end
      tdpt_pkg::ST_START: begin
        state_d = tdpt_pkg::ST_WAIT;
      end
      tdpt_pkg::ST_WAIT: begin
        if (div_done) begin
          if (trial_over || trial_hit) begin
            state_d = tdpt_pkg::ST_FINISH;
          end else begin
            state_d = tdpt_pkg::ST_START;
          end
        end
      end
      tdpt_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = tdpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tdpt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      tdpt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      tdpt_pkg::ST_START: begin
        div_start = 1'b1;
      end
      tdpt_pkg::ST_FINISH: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdpt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      n_q     <= number_i;
      d_q     <= W'(3);
      even_q  <= !number_i[0];
      prime_q <= small_n && number_i[1];
    end else if (state_q == tdpt_pkg::ST_WAIT && div_done) begin
      if (trial_over) begin
        prime_q <= 1'b1;
      end else if (trial_hit) begin
        prime_q <= 1'b0;
      end else begin
        d_q <= d_q + W'(2);
      end
    end
    if (out_load) begin
      out_prime_q <= prime_q;
      out_even_q  <= even_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_prime_o  = out_prime_q;
  assign is_even_o   = out_even_q;
  assign is_odd_o    = !out_even_q;

endmodule
